[rtl/eac_pkg.sv]
package eac_pkg;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_LSTART = 7'b0000001,
        PH_LOCAL  = 7'b0000010,
        PH_QUOTE  = 7'b0000100,
        PH_ESC    = 7'b0001000,
        PH_AFTERQ = 7'b0010000,
        PH_DSTART = 7'b0100000,
        PH_DOMAIN = 7'b1000000
    } phase_t;

    // Part tags on the result
    localparam logic [1:0] PART_LOCAL  = 2'd0;
    localparam logic [1:0] PART_AT     = 2'd1;
    localparam logic [1:0] PART_DOMAIN = 2'd2;

    // Register indexes
    localparam logic REG_MAX_LENGTH = 1'b0;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;

    function automatic logic is_special(input logic [7:0] c);
        return (c == 8'h28) || (c == 8'h29) || (c == 8'h3c) || (c == 8'h3e) ||
               (c == CH_AT) || (c == 8'h2c) || (c == 8'h3b) || (c == 8'h3a) ||
               (c == CH_BSLASH) || (c == CH_QUOTE) || (c == 8'h5b) ||
               (c == 8'h5d);
    endfunction

    function automatic logic is_ctl_or_high(input logic [7:0] c);
        return (c <= CH_SPACE) || (c >= CH_DEL);
    endfunction

endpackage

[rtl/email_address_syntax_checker.sv]
// Channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------
// input     | in_valid / in_stall        | in_char[7:0], last
// result    | out_valid / out_stall      | out_char[7:0], part[1:0], done_res,
//           |                            | valid_res
// config    | APB psel/penable/pwrite    | paddr[2:0], pwdata/prdata[31:0]
//
// One result item per input item, one item per cycle while out_stall is low.
// Each item passes the input register, then the parse update into the result
// register. The per-byte state machine update is the only logic between them.
// Reset (rst_n low, async) clears the parse state and loads max_length = 64.
// A stalled result holds in place; the input register then fills and
// in_stall rises until the result side drains.
module email_address_syntax_checker (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    input  logic        last,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic [1:0]  part,
    output logic        done_res,
    output logic        valid_res,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import eac_pkg::*;

    // ---------------- config register ----------------
    logic [7:0] max_length_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_MAX_LENGTH))
        begin
            max_length_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MAX_LENGTH)
        begin
            prdata = {24'd0, max_length_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    // ---------------- stage handshakes ----------------
    logic       s0_valid_reg;
    logic [7:0] s0_char_reg;
    logic       s0_last_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       s0_move;

    // result register can take a new item when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign s0_move  = s0_valid_reg && out_free;
    assign in_stall = s0_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s0_char_reg <= in_char;
            s0_last_reg <= last;
        end
    end

    // ---------------- parse state ----------------
    phase_t     phase_reg, phase_next;
    logic       prev_dot_reg, prev_dot_next;
    logic       prev_quote_reg, prev_quote_next;
    logic       dom_dot_reg, dom_dot_next;
    logic       failed_reg, failed_next;
    logic [7:0] count_reg, count_next;

    logic [7:0] c;
    logic [7:0] och;
    logic [1:0] part_v;
    logic       valid_v;
    logic [8:0] cnt;
    logic       bad_unq;

    assign c       = s0_char_reg;
    assign cnt     = {1'b0, count_reg} + 9'd1;
    assign bad_unq = is_ctl_or_high(c) || is_special(c);

    always_comb
    begin
        // case fold A..Z only
        och = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c ^ 8'h20) : c;
        part_v          = PART_LOCAL;
        valid_v         = 1'b0;
        phase_next      = phase_reg;
        prev_dot_next   = prev_dot_reg;
        prev_quote_next = prev_quote_reg;
        dom_dot_next    = dom_dot_reg;
        failed_next     = failed_reg || (cnt > {1'b0, max_length_reg});
        count_next      = cnt[8] ? 8'hff : cnt[7:0];

        unique case (phase_reg)
            PH_LSTART, PH_LOCAL:
            begin
                if ((c == CH_QUOTE) &&
                    ((phase_reg == PH_LSTART) || prev_dot_reg || prev_quote_reg))
                begin
                    phase_next      = PH_QUOTE;
                    prev_dot_next   = 1'b0;
                    prev_quote_next = 1'b0;
                end
                else if (c == CH_AT)
                begin
                    // empty local part or trailing dot
                    if ((phase_reg == PH_LSTART) || prev_dot_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    part_v          = PART_AT;
                    phase_next      = PH_DSTART;
                    prev_dot_next   = 1'b0;
                    prev_quote_next = 1'b0;
                end
                else
                begin
                    if (bad_unq)
                    begin
                        failed_next = 1'b1;
                    end
                    prev_dot_next   = (c == CH_DOT);
                    prev_quote_next = (c == CH_QUOTE);
                    phase_next      = PH_LOCAL;
                end
            end
            PH_QUOTE:
            begin
                och = c;
                if (c == CH_QUOTE)
                begin
                    phase_next = PH_AFTERQ;
                end
                else if (c == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else if (is_ctl_or_high(c))
                begin
                    failed_next = 1'b1;
                end
            end
            PH_ESC:
            begin
                och = c;
                if ((c != CH_SPACE) && is_ctl_or_high(c))
                begin
                    failed_next = 1'b1;
                end
                phase_next = PH_QUOTE;
            end
            PH_AFTERQ:
            begin
                if (c == CH_AT)
                begin
                    part_v        = PART_AT;
                    phase_next    = PH_DSTART;
                    prev_dot_next = 1'b0;
                end
                else
                begin
                    if (c != CH_DOT)
                    begin
                        failed_next = 1'b1;
                    end
                    prev_dot_next = (c == CH_DOT);
                    phase_next    = PH_LOCAL;
                end
                prev_quote_next = 1'b0;
            end
            default:
            begin
                // domain start and domain
                part_v = PART_DOMAIN;
                if (c == CH_DOT)
                begin
                    if ((phase_reg != PH_DOMAIN) || prev_dot_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    dom_dot_next = 1'b1;
                end
                if (bad_unq)
                begin
                    failed_next = 1'b1;
                end
                prev_dot_next = (c == CH_DOT);
                phase_next    = PH_DOMAIN;
            end
        endcase

        // end of address: report, then start over
        if (s0_last_reg)
        begin
            valid_v         = !failed_next && (phase_next == PH_DOMAIN) && dom_dot_next;
            phase_next      = PH_LSTART;
            prev_dot_next   = 1'b0;
            prev_quote_next = 1'b0;
            dom_dot_next    = 1'b0;
            failed_next     = 1'b0;
            count_next      = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LSTART;
            prev_dot_reg   <= 1'b0;
            prev_quote_reg <= 1'b0;
            dom_dot_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            count_reg      <= 8'd0;
        end
        else if (s0_move)
        begin
            phase_reg      <= phase_next;
            prev_dot_reg   <= prev_dot_next;
            prev_quote_reg <= prev_quote_next;
            dom_dot_reg    <= dom_dot_next;
            failed_reg     <= failed_next;
            count_reg      <= count_next;
        end
    end

    // ---------------- result register ----------------
    logic [7:0] out_char_reg;
    logic [1:0] part_reg;
    logic       done_reg;
    logic       valid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_move)
        begin
            out_char_reg  <= och;
            part_reg      <= part_v;
            done_reg      <= s0_last_reg;
            valid_res_reg <= valid_v;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign part      = part_reg;
    assign done_res  = done_reg;
    assign valid_res = valid_res_reg;

    // ---------------- checks ----------------
    a_valid_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> !valid_res_reg)
        else $error("valid_res set on a non-final item");

    a_at_tag_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (part_reg == PART_AT) |-> (out_char_reg == CH_AT))
        else $error("at tag on a byte other than the at sign");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s0_move && s0_last_reg |=> (phase_reg == PH_LSTART) && (count_reg == 8'd0))
        else $error("parse state not cleared after final byte");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s0_valid_reg && out_valid_reg)
        else $error("input stalled with free pipeline");

endmodule
